FILE: rtl/smc_pkg.sv
`default_nettype none
package smc_pkg;

  typedef enum logic [1:0] {
    MODE_BRAKE    = 2'd0,
    MODE_COAST    = 2'd1,
    MODE_THROTTLE = 2'd2,
    MODE_BOOST    = 2'd3
  } drive_mode_e;

  localparam int unsigned RT_W   = 20;
  localparam int unsigned CURV_W = 18;
  localparam int unsigned REM_W  = 40;
  localparam int unsigned DVS_W  = 38;
  localparam int unsigned QUO_W  = 15;

  localparam logic [RT_W-1:0] RT_RESET = 20'd40000;

  // Accelerations are kept in units of 1/1680 per second squared.
  localparam logic signed [22:0] BC_THRESH   = -23'sd3131100;
  localparam logic signed [22:0] CT_THRESH   = -23'sd441000;
  localparam logic signed [22:0] TILT_THRESH = -23'sd2940000;
  localparam logic [21:0]        BOOST_HALF  = 22'd833000;
  localparam logic signed [27:0] LHS_K       = 28'sd105000000;
  localparam logic signed [24:0] NUM_K       = 25'sd8750000;
  localparam logic signed [15:0] UP_TILT_LIM = 16'sd11469;

  localparam logic signed [15:0] THR_ONE = 16'sd16384;
  localparam logic signed [15:0] THR_NEG = -16'sd16384;
  localparam logic signed [15:0] THR_MIN = 16'sd328;

  typedef struct packed {
    drive_mode_e        mode;
    logic               force_max;
    logic               force_min;
    logic [REM_W-1:0]   rem;
    logic [DVS_W-1:0]   dvs;
  } smc_work_t;

endpackage
`default_nettype wire

FILE: rtl/smc_front.sv
`default_nettype none
module smc_front import smc_pkg::*; (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      in_valid_i,
  output logic                     in_ready_o,
  input  wire signed [16:0]        target_speed_i,
  input  wire signed [16:0]        forward_speed_i,
  input  wire signed [15:0]        up_vertical_i,
  input  wire        [RT_W-1:0]    reaction_time_i,
  output logic                     out_valid_o,
  input  wire                      out_ready_i,
  output smc_work_t                out_work_o
);

  logic [2:0] v_q;
  logic       rdy1, rdy2, rdy3;

  assign rdy3       = !v_q[2] || out_ready_i;
  assign rdy2       = !v_q[1] || rdy3;
  assign rdy1       = !v_q[0] || rdy2;
  assign in_ready_o = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy1) v_q[0] <= in_valid_i;
      if (rdy2) v_q[1] <= v_q[0];
      if (rdy3) v_q[2] <= v_q[1];
    end
  end

  // Stage 1: speed error, curve value, tilt test.
  logic signed [17:0]       diff_d, diff_q;
  logic        [16:0]       spd;
  logic        [CURV_W-1:0] c_knee, c_end, curv_d, curv_q;
  logic                     tilt_d, tilt_q;
  logic        [RT_W-1:0]   rt_d, rt_q;

  always_comb begin
    diff_d = {target_speed_i[16], target_speed_i} - {forward_speed_i[16], forward_speed_i};
    spd    = forward_speed_i[16] ? (~forward_speed_i + 17'd1) : forward_speed_i;
    c_knee = 18'd224000 - (18'(spd) * 18'd9);
    c_end  = (18'd22560 - 18'(spd)) * 18'd140;
    if (spd < 17'd22400) begin
      curv_d = c_knee;
    end else if (spd < 17'd22560) begin
      curv_d = c_end;
    end else begin
      curv_d = '0;
    end
    tilt_d = up_vertical_i < UP_TILT_LIM;
    rt_d   = (reaction_time_i == '0) ? RT_W'(1) : reaction_time_i;
  end

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      diff_q <= diff_d;
      curv_q <= curv_d;
      tilt_q <= tilt_d;
      rt_q   <= rt_d;
    end
  end

  // Stage 2: scale everything by the reaction time.
  logic signed [22:0]      bc_sel, ct_sel;
  logic signed [20:0]      rt_s;
  logic        [21:0]      tb;
  logic signed [45:0]      lhs_d, lhs_q;
  logic signed [43:0]      bc_d, bc_q, ct_d, ct_q;
  logic        [41:0]      tb_d, tb_q;
  logic signed [42:0]      num_d, num_q;
  logic        [DVS_W-1:0] dvs_d, dvs_q;
  logic                    cz_d, cz_q;

  always_comb begin
    bc_sel = tilt_q ? TILT_THRESH : BC_THRESH;
    ct_sel = tilt_q ? TILT_THRESH : CT_THRESH;
    rt_s   = $signed({1'b0, rt_q});
    tb     = {curv_q, 3'b000} + {1'b0, curv_q, 2'b00} + BOOST_HALF;
    lhs_d  = diff_q * LHS_K;
    bc_d   = bc_sel * rt_s;
    ct_d   = ct_sel * rt_s;
    tb_d   = tb * rt_q;
    num_d  = diff_q * NUM_K;
    dvs_d  = rt_q * curv_q;
    cz_d   = curv_q == '0;
  end

  always_ff @(posedge clk_i) begin
    if (rdy2) begin
      lhs_q <= lhs_d;
      bc_q  <= bc_d;
      ct_q  <= ct_d;
      tb_q  <= tb_d;
      num_q <= num_d;
      dvs_q <= dvs_d;
      cz_q  <= cz_d;
    end
  end

  // Stage 3: threshold compares and divider setup.
  smc_work_t   work_d, work_q;
  logic        num_pos;
  logic        num_big;

  always_comb begin
    num_pos = !num_q[42] && (num_q != '0);
    num_big = $unsigned(num_q) >= 43'({dvs_q, 1'b0});
    if (lhs_q <= 46'(bc_q)) begin
      work_d.mode = MODE_BRAKE;
    end else if (lhs_q < 46'(ct_q)) begin
      work_d.mode = MODE_COAST;
    end else if (lhs_q <= $signed({4'b0000, tb_q})) begin
      work_d.mode = MODE_THROTTLE;
    end else begin
      work_d.mode = MODE_BOOST;
    end
    work_d.force_max = cz_q || (num_pos && num_big);
    work_d.force_min = !num_pos;
    work_d.rem       = num_q[REM_W-1:0];
    work_d.dvs       = dvs_q;
  end

  always_ff @(posedge clk_i) begin
    if (rdy3) begin
      work_q <= work_d;
    end
  end

  assign out_valid_o = v_q[2];
  assign out_work_o  = work_q;

endmodule
`default_nettype wire

FILE: rtl/smc_div.sv
`default_nettype none
module smc_div import smc_pkg::*; (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  output logic               in_ready_o,
  input  smc_work_t          in_work_i,
  output logic               out_valid_o,
  input  wire                out_ready_i,
  output smc_work_t          out_work_o,
  output logic [QUO_W-1:0]   out_quo_o
);

  // One quotient bit per stage, most significant first. The remainder
  // enters below twice the divisor and stays below the divisor afterwards.
  logic [QUO_W-1:0] v_q;
  logic [QUO_W:0]   rdy;
  smc_work_t        w_q [QUO_W];
  logic [QUO_W-1:0] q_q [QUO_W];

  assign rdy[QUO_W] = out_ready_i;

  for (genvar j = 0; j < QUO_W; j++) begin : g_step
    smc_work_t        w_in, w_out;
    logic [QUO_W-1:0] q_in;
    logic             v_in;
    logic [REM_W:0]   trial;
    logic             ge;

    if (j == 0) begin : g_first
      assign w_in  = in_work_i;
      assign q_in  = '0;
      assign v_in  = in_valid_i;
      assign trial = {1'b0, in_work_i.rem};
    end else begin : g_next
      assign w_in  = w_q[j-1];
      assign q_in  = q_q[j-1];
      assign v_in  = v_q[j-1];
      assign trial = {w_q[j-1].rem, 1'b0};
    end

    assign rdy[j] = !v_q[j] || rdy[j+1];

    always_comb begin
      ge        = trial >= {3'b000, w_in.dvs};
      w_out     = w_in;
      w_out.rem = ge ? REM_W'(trial - {3'b000, w_in.dvs}) : REM_W'(trial);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[j] <= 1'b0;
      end else if (rdy[j]) begin
        v_q[j] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[j]) begin
        w_q[j] <= w_out;
        q_q[j] <= {q_in[QUO_W-2:0], ge};
      end
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = v_q[QUO_W-1];
  assign out_work_o  = w_q[QUO_W-1];
  assign out_quo_o   = q_q[QUO_W-1];

endmodule
`default_nettype wire

FILE: rtl/speed_mode_controller_top.sv
// Speed mode controller.
// Input channel: one beat carries target_speed_i, forward_speed_i and
// up_vertical_i; it is taken when in_valid_i is high and in_stall_o is low.
// Output channel: one beat per input beat with throttle_cmd_o, boost_on_o
// and drive_mode_o, taken when out_valid_o is high and out_stall_i is low.
// The reaction time register is written through cfg_valid_i/cfg_data_i;
// cfg_ready_o is always high. Write it only while no beat is in flight.
// The path has three stages of compare and multiply, a 15-stage
// restoring divider that produces one quotient bit per stage, and the
// output register. Throughput is one beat per cycle while not stalled.
// When out_stall_i is high, each stage holds its beat and empty stages
// keep filling, so new beats are still accepted until the pipeline is full;
// in_stall_o then rises. Nothing is dropped or repeated.
// Reset empties the pipeline and sets the reaction time to 40000 us.
`default_nettype none
module speed_mode_controller_top import smc_pkg::*; (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  output logic               in_stall_o,
  input  wire signed [16:0]  target_speed_i,
  input  wire signed [16:0]  forward_speed_i,
  input  wire signed [15:0]  up_vertical_i,
  output logic               out_valid_o,
  input  wire                out_stall_i,
  output logic signed [15:0] throttle_cmd_o,
  output logic               boost_on_o,
  output logic [1:0]         drive_mode_o,
  input  wire                cfg_valid_i,
  output logic               cfg_ready_o,
  input  wire [RT_W-1:0]     cfg_data_i
);

  logic [RT_W-1:0] rt_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rt_q <= RT_RESET;
    end else if (cfg_valid_i) begin
      rt_q <= cfg_data_i;
    end
  end

  logic             front_ready, front_valid, div_ready, div_valid;
  smc_work_t        front_work, div_work;
  logic [QUO_W-1:0] div_quo;
  logic             out_ready;

  smc_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (front_ready),
    .target_speed_i  (target_speed_i),
    .forward_speed_i (forward_speed_i),
    .up_vertical_i   (up_vertical_i),
    .reaction_time_i (rt_q),
    .out_valid_o     (front_valid),
    .out_ready_i     (div_ready),
    .out_work_o      (front_work)
  );

  smc_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (front_valid),
    .in_ready_o  (div_ready),
    .in_work_i   (front_work),
    .out_valid_o (div_valid),
    .out_ready_i (out_ready),
    .out_work_o  (div_work),
    .out_quo_o   (div_quo)
  );

  assign in_stall_o = !front_ready;

  logic               out_v_q;
  logic signed [15:0] thr_d, thr_q;
  logic               boost_d, boost_q;
  drive_mode_e        mode_q;

  assign out_ready = !out_v_q || !out_stall_i;

  always_comb begin
    boost_d = 1'b0;
    unique case (div_work.mode)
      MODE_BRAKE: thr_d = THR_NEG;
      MODE_COAST: thr_d = '0;
      MODE_BOOST: begin
        thr_d   = THR_ONE;
        boost_d = 1'b1;
      end
      MODE_THROTTLE: begin
        priority if (div_work.force_max) begin
          thr_d = THR_ONE;
        end else if (div_work.force_min) begin
          thr_d = THR_MIN;
        end else if ({1'b0, div_quo} < THR_MIN) begin
          thr_d = THR_MIN;
        end else if ({1'b0, div_quo} > THR_ONE) begin
          thr_d = THR_ONE;
        end else begin
          thr_d = {1'b0, div_quo};
        end
      end
      default: thr_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_ready) begin
      out_v_q <= div_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready) begin
      thr_q   <= thr_d;
      boost_q <= boost_d;
      mode_q  <= div_work.mode;
    end
  end

  assign out_valid_o    = out_v_q;
  assign throttle_cmd_o = thr_q;
  assign boost_on_o     = boost_q;
  assign drive_mode_o   = mode_q;

endmodule
`default_nettype wire

FILE: tb/sv/speed_mode_checker.sv
`timescale 1ns / 1ps
module speed_mode_checker import smc_pkg::*; (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               in_valid_i,
  input  wire               in_stall_i,
  input  wire signed [16:0] target_speed_i,
  input  wire signed [16:0] forward_speed_i,
  input  wire signed [15:0] up_vertical_i,
  input  wire               out_valid_i,
  input  wire               out_stall_i,
  input  wire signed [15:0] throttle_cmd_i,
  input  wire               boost_on_i,
  input  wire [1:0]         drive_mode_i,
  input  wire               cfg_valid_i,
  input  wire               cfg_ready_i,
  input  wire [RT_W-1:0]    cfg_data_i,
  output int                fail_count_o,
  output int                pending_o
);

  typedef struct packed {
    logic signed [15:0] thr;
    logic               boost;
    drive_mode_e        mode;
  } drive_cmd_t;

  drive_cmd_t  cmd_q[$];
  logic [RT_W-1:0] react_us;

  // Throttle-acceleration curve scaled by 140.
  function automatic longint accel_curve(longint spd);
    if (spd < 22400) return 224000 - 9 * spd;
    if (spd < 22560) return 140 * (22560 - spd);
    return 0;
  endfunction

  function automatic drive_cmd_t predict_drive(logic signed [16:0] tgt,
                                               logic signed [16:0] fwd,
                                               logic signed [15:0] upz,
                                               logic [RT_W-1:0] rtv);
    longint rt, diff, spd, crv, lhs, bc, ct, tb, num, q;
    drive_cmd_t r;
    rt = (rtv == 0) ? 1 : longint'(rtv);
    diff = longint'(tgt) - longint'(fwd);
    spd = (fwd < 0) ? -longint'(fwd) : longint'(fwd);
    crv = accel_curve(spd);
    lhs = diff * 105000000;
    bc = -3131100;
    ct = -441000;
    tb = crv * 12 + 833000;
    // A tilted vehicle has no coast band.
    if (longint'(upz) * 10 < 114688) begin
      bc = -2940000;
      ct = -2940000;
    end
    r.boost = 1'b0;
    if (lhs <= bc * rt) begin
      r.thr = -16'sd16384; r.mode = MODE_BRAKE;
    end else if (lhs < ct * rt) begin
      r.thr = 16'sd0; r.mode = MODE_COAST;
    end else if (lhs <= tb * rt) begin
      r.mode = MODE_THROTTLE;
      if (crv == 0) r.thr = 16'sd16384;
      else begin
        num = diff * 8750000 * 16384;
        if (num <= 0) q = 328;
        else begin
          q = num / (rt * crv);
          if (q < 328) q = 328;
          if (q > 16384) q = 16384;
        end
        r.thr = q[15:0];
      end
    end else begin
      r.thr = 16'sd16384; r.boost = 1'b1; r.mode = MODE_BOOST;
    end
    return r;
  endfunction

  assign pending_o = cmd_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    drive_cmd_t want;
    if (!rst_ni) begin
      react_us <= RT_RESET;
      fail_count_o <= 0;
      cmd_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) react_us <= cfg_data_i;
      if (in_valid_i && !in_stall_i)
        cmd_q.push_back(predict_drive(target_speed_i, forward_speed_i, up_vertical_i,
                                      react_us));
      if (out_valid_i && !out_stall_i) begin
        if (cmd_q.size() == 0) begin
          $error("result beat with nothing expected");
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = cmd_q.pop_front();
          if (throttle_cmd_i !== want.thr || boost_on_i !== want.boost ||
              drive_mode_i !== want.mode) begin
            fail_count_o <= fail_count_o + 1;
            if (throttle_cmd_i !== want.thr)
              $error("throttle_cmd expected %0d got %0d", want.thr, throttle_cmd_i);
            if (boost_on_i !== want.boost)
              $error("boost_on expected %0d got %0d", want.boost, boost_on_i);
            if (drive_mode_i !== want.mode)
              $error("drive_mode expected %0d got %0d", want.mode, drive_mode_i);
          end
        end
      end
    end
  end

endmodule

FILE: tb/sv/tb_speed_mode_controller_top.sv
`timescale 1ns / 1ps
module tb_speed_mode_controller_top;
  import smc_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [16:0] target_speed_i = '0;
  logic signed [16:0] forward_speed_i = '0;
  logic signed [15:0] up_vertical_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [15:0] throttle_cmd_o;
  logic boost_on_o;
  logic [1:0] drive_mode_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [RT_W-1:0] cfg_data_i = '0;
  int fail_count, pending;
  int send_idle_pct = 0, recv_idle_pct = 0;
  int hold_cycles = 0;
  longint cycle_count = 0;

  always #5 clk_i = ~clk_i;

  speed_mode_controller_top u_top (.*);

  speed_mode_checker u_chk (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .target_speed_i,
    .forward_speed_i, .up_vertical_i, .out_valid_i(out_valid_o), .out_stall_i,
    .throttle_cmd_i(throttle_cmd_o), .boost_on_i(boost_on_o), .drive_mode_i(drive_mode_o),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_data_i, .fail_count_o(fail_count),
    .pending_o(pending)
  );

  // Receiver: random stalls, or a long hold-off when requested.
  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      out_stall_i <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("tb_speed_mode_controller_top: FAIL");
      $finish;
    end
  end

  task automatic send_beat(input logic signed [16:0] tgt, input logic signed [16:0] fwd,
                           input logic signed [15:0] upz);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    target_speed_i <= tgt;
    forward_speed_i <= fwd;
    up_vertical_i <= upz;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic drain_pipe();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (25) @(posedge clk_i);
  endtask

  task automatic write_react(input logic [RT_W-1:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Mostly speeds in the working range, so every mode is hit; some full-range noise.
  task automatic send_random(input int n);
    logic signed [16:0] fwd, tgt;
    logic signed [15:0] upz;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(3) == 0) begin
        fwd = 17'($urandom);
        tgt = 17'($urandom);
        upz = 16'($urandom);
      end else begin
        fwd = 17'($signed($urandom_range(48000)) - 24000);
        tgt = 17'(fwd + $signed($urandom_range(4000)) - 2000);
        if ($urandom_range(1)) tgt = 17'(fwd + $signed($urandom_range(40)) - 20);
        upz = ($urandom_range(1)) ? 16'($signed($urandom_range(16384)))
                                  : 16'($signed($urandom_range(32767)) - 16384);
      end
      send_beat(tgt, fwd, upz);
    end
  endtask

  logic [RT_W-1:0] rt_set[6] = '{20'd1, 20'd1000000, 20'd0, 20'hFFFFF, 20'd40000, 20'd137};

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // Directed: field extremes, each mode, curve knee and end, tilt edge.
    send_beat(17'sd0, 17'sd0, 16'sd16384);
    send_beat(17'sd65535, -17'sd65536, 16'sd16384);
    send_beat(-17'sd65536, 17'sd65535, -16'sd16384);
    send_beat(-17'sd65536, -17'sd65536, 16'sd11469);
    send_beat(17'sd0, 17'sd5, 16'sd11468);
    send_beat(17'sd0, 17'sd100, 16'sd11469);
    send_beat(17'sd22460, 17'sd22400, 16'sd16384);
    send_beat(17'sd22600, 17'sd22559, 16'sd16384);
    send_beat(17'sd22600, 17'sd22560, 16'sd16384);
    send_beat(-17'sd22500, -17'sd22600, 16'sd0);
    send_beat(17'sd40, 17'sd0, 16'sd16384);
    send_beat(17'sd1, 17'sd0, 16'sd16384);
    send_beat(17'sd2000, 17'sd0, 16'sd16384);
    send_beat(17'sd0, 17'sd0, -16'sd32768);
    send_beat(17'sd0, 17'sd0, 16'sd32767);
    send_beat(17'sd100, 17'sd0, -16'sd1);
    drain_pipe();
    for (int ph = 0; ph < 6; ph++) begin
      write_react(rt_set[ph]);
      case (ph % 3)
        0: begin send_idle_pct = 24; recv_idle_pct = 65; end
        1: begin send_idle_pct = 65; recv_idle_pct = 24; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      if (ph == 5) hold_cycles <= 80;
      send_random(265);
      drain_pipe();
    end
    if (fail_count == 0) begin
      $display("tb_speed_mode_controller_top: PASS");
    end else begin
      $display("tb_speed_mode_controller_top: FAIL");
    end
    $finish;
  end

endmodule

FILE: speed_mode_controller_top.f
rtl/smc_pkg.sv
rtl/smc_front.sv
rtl/smc_div.sv
rtl/speed_mode_controller_top.sv
tb/sv/speed_mode_checker.sv
tb/sv/tb_speed_mode_controller_top.sv
